### src/assert_macros.svh
// Assertion macros used by the checker file ishear_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ishear_pkg.sv
// ----------------------------------------------------------------------------
// ishear_pkg
// Types and constants for the shear inverse mapper.
// ----------------------------------------------------------------------------
package ishear_pkg;

	localparam int MaxWidth  = 256;
	localparam int MaxHeight = 256;
	localparam int ColW = $clog2(MaxWidth);
	localparam int RowW = $clog2(MaxHeight);
	localparam int AddrW = ColW + RowW;

	// Numerator and denominator widths (magnitudes)
	localparam int NumW = 42;
	localparam int DenW = 34;
	// Quotient bits needed: quotient < lim <= 256, test decides before use
	localparam int QW = 9;

	localparam logic [1:0] RegWidth  = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;
	localparam logic [1:0] RegShearX = 2'd2;
	localparam logic [1:0] RegShearY = 2'd3;

	localparam logic FuncWrite = 1'b0;
	localparam logic FuncRead  = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       mapped;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_NUM,
		ST_DIV,
		ST_READ,
		ST_OUT
	} state_t;

	// Status passed from the divider to the control
	typedef struct packed {
		logic           done;
		logic           ok;
		logic [QW-1:0]  quot;
	} div_stat_t;

endpackage

### src/ishear_div.sv
// ----------------------------------------------------------------------------
// ishear_div
// Restoring divider with range test: checks 0 <= num/den < lim, gives floor.
// ----------------------------------------------------------------------------
module ishear_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic                      num_neg,
	input  logic [ishear_pkg::NumW-1:0] num_mag,
	input  logic                      den_neg,
	input  logic [ishear_pkg::DenW-1:0] den_mag,
	input  logic [8:0]                lim,
	output ishear_pkg::div_stat_t     stat
);
	import ishear_pkg::*;

	localparam int RemW = DenW + 1;
	localparam int CntW = $clog2(QW + 1);

	logic [NumW-1:0] num_q;
	logic [DenW-1:0] den_q;
	logic [RemW-1:0] rem_q;
	logic [QW-1:0]   quot_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            ok_q;
	logic            done_q;
	logic [RemW-1:0] trial;
	logic [RemW-1:0] diff;

	// Quotient bits above QW imply num >= 512*den, which fails the range test
	logic [NumW+8:0] lim_prod;
	assign lim_prod = den_mag * lim;

	// Shift in one numerator bit per cycle; the low QW bits form the quotient
	assign trial = {rem_q[DenW-1:0], num_q[NumW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				// sign and bound test on the exact quotient
				ok_q <= !((num_mag != '0) && (num_neg != den_neg)) &&
					({9'd0, num_mag} < lim_prod);
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: pre-load the remainder with the high numerator bits
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= RemW'(num_mag >> QW);
			num_q  <= num_mag << (NumW - QW);
			den_q  <= den_mag;
			quot_q <= '0;
		end else if (busy_q) begin
			if (!diff[RemW-1]) begin
				rem_q  <= diff;
				quot_q <= {quot_q[QW-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[QW-2:0], 1'b0};
			end
			num_q <= num_q << 1;
		end
	end

	assign stat.done = done_q;
	assign stat.ok   = ok_q;
	assign stat.quot = quot_q;

endmodule

### src/image_shear_inverse_map_core.sv
// ----------------------------------------------------------------------------
// image_shear_inverse_map_core
// Nearest-neighbour inverse shear mapper over a stored 8-bit source frame.
// ----------------------------------------------------------------------------
// Channel   | Handshake        | Payload
// request   | start / busy     | req  (func, row, col, pixel_in)
// result    | res_valid strobe | res  (pixel_out, mapped)
// config    | cfg_we           | cfg_index, cfg_data
//
// A write request does not raise busy. A read request holds busy through the
// products, the numerators, the two serial dividers (one per axis, run side
// by side), one frame memory read and one output step. The result strobe is
// registered from the output step, while the next request can already be
// taken. The frame memory is not cleared at reset; registers reset to
// 256x256, no shear. The result strobe lasts one cycle and cannot be stalled.
module image_shear_inverse_map_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ishear_pkg::req_t  req,
	output logic              res_valid,
	output ishear_pkg::res_t  res,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import ishear_pkg::*;

	logic [8:0]         width_q, height_q;
	logic signed [15:0] sx_q, sy_q;
	state_t             state_q, state_d;
	req_t               req_q;
	logic [7:0]         frame [MaxWidth*MaxHeight];
	logic [7:0]         rd_q;
	logic signed [31:0] det_q;   // 2^24 - sx*sy
	logic signed [24:0] psx_q, psy_q; // sx*row, sy*col
	logic signed [41:0] nx_q, ny_q;
	logic               okpre_q;
	logic               ok_q;
	logic [8:0]         w_eff, h_eff;
	logic               accept;
	logic               go;
	div_stat_t          sx_stat, sy_stat;
	res_t               res_q;
	logic               valid_q;
	logic signed [31:0] sxy;

	assign accept = start && !busy;
	assign w_eff = (width_q  > 9'(MaxWidth))  ? 9'(MaxWidth)  : width_q;
	assign h_eff = (height_q > 9'(MaxHeight)) ? 9'(MaxHeight) : height_q;
	assign sxy = sx_q * sy_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			sx_q     <= '0;
			sy_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegWidth:  width_q  <= cfg_data[8:0];
				RegHeight: height_q <= cfg_data[8:0];
				RegShearX: sx_q     <= cfg_data;
				RegShearY: sy_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the request
	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
	end

	// Frame memory: write on a write request, read the mapped address
	always_ff @(posedge clk) begin
		if (accept && req.func == FuncWrite)
			frame[{req.row, req.col}] <= req.pixel_in;
		if (state_q == ST_READ)
			rd_q <= frame[{sy_stat.quot[RowW-1:0], sx_stat.quot[ColW-1:0]}];
	end

	// Products, then numerators
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			det_q  <= 32'sd16777216 - sxy;
			psx_q  <= sx_q * $signed({1'b0, req_q.row});
			psy_q  <= sy_q * $signed({1'b0, req_q.col});
			okpre_q <= (req_q.row < h_eff) && (req_q.col < w_eff);
		end
		if (state_q == ST_NUM) begin
			nx_q <= ($signed({34'd0, req_q.col}) <<< 24) - ($signed({{17{psx_q[24]}}, psx_q}) <<< 12);
			ny_q <= ($signed({34'd0, req_q.row}) <<< 24) - ($signed({{17{psy_q[24]}}, psy_q}) <<< 12);
			okpre_q <= okpre_q && (det_q != 0);
		end
	end

	assign go = (state_q == ST_DIV) && !sx_stat.done && !ok_q;

	logic [NumW-1:0] nx_mag, ny_mag;
	logic [DenW-1:0] det_mag;
	assign nx_mag  = nx_q[41] ? NumW'(-nx_q) : NumW'(nx_q);
	assign ny_mag  = ny_q[41] ? NumW'(-ny_q) : NumW'(ny_q);
	assign det_mag = det_q[31] ? DenW'(-det_q) : DenW'(det_q);

	// Launch both axis divisions once per read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ok_q <= 1'b0;
		else if (state_q == ST_NUM) ok_q <= 1'b0;
		else if (state_q == ST_DIV) ok_q <= 1'b1;
	end

	ishear_div u_div_x (
		.clk, .arst_n, .go,
		.num_neg(nx_q[41]), .num_mag(nx_mag),
		.den_neg(det_q[31]), .den_mag(det_mag),
		.lim(w_eff), .stat(sx_stat)
	);

	ishear_div u_div_y (
		.clk, .arst_n, .go,
		.num_neg(ny_q[41]), .num_mag(ny_mag),
		.den_neg(det_q[31]), .den_mag(det_mag),
		.lim(h_eff), .stat(sy_stat)
	);

	logic map_ok_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_READ)
			map_ok_q <= okpre_q && sx_stat.ok && sy_stat.ok;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && req.func == FuncRead) state_d = ST_MUL;
			ST_MUL:  state_d = ST_NUM;
			ST_NUM:  state_d = ST_DIV;
			ST_DIV:  if (sx_stat.done) state_d = ST_READ;
			ST_READ: state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= (state_q == ST_OUT);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			res_q.mapped    <= map_ok_q;
			res_q.pixel_out <= map_ok_q ? rd_q : 8'd0;
		end
	end

	assign res_valid = valid_q;
	assign res = res_q;

endmodule

### src/ishear_chk.sv
// ----------------------------------------------------------------------------
// ishear_chk
// Port-level checks on the shear inverse mapper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ishear_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input ishear_pkg::req_t req,
	input logic             res_valid
);
	import ishear_pkg::*;

	// a write request leaves the block free
	`ASSERT_NEXT(a_wr_free, clk, arst_n, start && !busy && req.func == FuncWrite, !busy && !res_valid, "write left block busy")
	// a read request occupies the block
	`ASSERT_NEXT(a_rd_busy, clk, arst_n, start && !busy && req.func == FuncRead, busy, "read did not start")
	// a result is a single strobe
	`ASSERT_NEXT(a_strobe, clk, arst_n, res_valid, !res_valid, "result strobe longer than a cycle")
	// the result ends the busy period
	`ASSERT_IMPLY(a_res_end, clk, arst_n, res_valid, $fell(busy), "result outside end of busy")

endmodule

bind image_shear_inverse_map_core ishear_chk u_chk (
	.clk, .arst_n, .start, .busy, .req, .res_valid
);
